// File: hdl/relay_packet_cache_with_locks_top_assert.svh
// Assertion macros used by the relay packet cache RTL.
// Included by rpc_dp, which checks its own logic; depends on nothing.
`ifndef RELAY_PACKET_CACHE_WITH_LOCKS_TOP_ASSERT_SVH
`define RELAY_PACKET_CACHE_WITH_LOCKS_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rpc_pkg.sv
// Shared types, codes and constants of the relay packet cache.
// Used by every RTL module of the block; depends on nothing.
package rpc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned MAX_SLOTS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned NB_W    = 5;
  localparam int unsigned HIT_W   = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Item operation codes.
  localparam logic [OP_W-1:0] OP_STORE   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_CACHE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_NUM_BLOCKS     = 2'd1;
  localparam logic [1:0] REG_INVALID_MARKER = 2'd2;

  // Register reset values.
  localparam logic [NB_W-1:0]  NUM_BLOCKS_RST     = 5'd16;
  localparam logic [SEQ_W-1:0] INVALID_MARKER_RST = 16'hFFFF;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] seq_no;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic [SEQ_W-1:0]  seq_out;
    logic              forward;
    logic              more_pending;
    logic [HIT_W-1:0]  hit_total;
  } result_t;

  typedef struct packed {
    logic             cache_enable;
    logic [NB_W-1:0]  num_blocks;
    logic [SEQ_W-1:0] invalid_marker;
  } cfg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_STORE,
    ST_LOOK
  } state_e;

  // Datapath actions; all but NONE and STEP finish the item with a result.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STEP,
    ACT_STORE,
    ACT_BLANK,
    ACT_HIT,
    ACT_MISS,
    ACT_SKIP,
    ACT_POP
  } act_e;

  typedef struct packed {
    logic load;
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            enable;
    logic            is_marker;
    logic            lock_free;
    logic            match;
    logic            at_end;
    logic            q_empty;
    logic            q_full;
    logic            out_free;
  } sts_t;

endpackage

// File: hdl/rpc_stream_if.sv
// Valid/ready stream channel carrying one word of payload type T.
// Depends on nothing; the payload type comes from rpc_pkg at instantiation.
interface rpc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rpc_cfg.sv
// APB-style configuration registers of the relay packet cache.
// Depends on rpc_pkg.
module rpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpc_pkg::PADDR_W-1:0]    paddr,
  input  logic [rpc_pkg::PDATA_W-1:0]    pwdata,
  output logic [rpc_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  output rpc_pkg::cfg_t                  cfg_o
);

  rpc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        rpc_pkg::REG_CACHE_ENABLE:   cfg_d.cache_enable   = pwdata[0];
        rpc_pkg::REG_NUM_BLOCKS:     cfg_d.num_blocks     = pwdata[rpc_pkg::NB_W-1:0];
        rpc_pkg::REG_INVALID_MARKER: cfg_d.invalid_marker = pwdata[rpc_pkg::SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_enable   <= 1'b0;
      cfg_q.num_blocks     <= rpc_pkg::NUM_BLOCKS_RST;
      cfg_q.invalid_marker <= rpc_pkg::INVALID_MARKER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register; unused addresses read zero.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      rpc_pkg::REG_CACHE_ENABLE:   prdata[0] = cfg_q.cache_enable;
      rpc_pkg::REG_NUM_BLOCKS:     prdata[rpc_pkg::NB_W-1:0] = cfg_q.num_blocks;
      rpc_pkg::REG_INVALID_MARKER: prdata[rpc_pkg::SEQ_W-1:0] = cfg_q.invalid_marker;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/rpc_ctrl.sv
// Controller state machine of the relay packet cache.
// Depends on rpc_pkg; drives the datapath through cmd_t and reads sts_t.
module rpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpc_pkg::sts_t sts_i,
  output rpc_pkg::cmd_t cmd_o
);

  rpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. A finishing step waits until the result register is free.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rpc_pkg::ST_DISPATCH;
      end
      rpc_pkg::ST_DISPATCH: begin
        unique case (sts_i.op)
          rpc_pkg::OP_STORE: begin
            if (sts_i.enable) state_d = rpc_pkg::ST_STORE;
            else if (sts_i.out_free) state_d = rpc_pkg::ST_IDLE;
          end
          rpc_pkg::OP_LOOKUP: begin
            if (sts_i.enable && !sts_i.is_marker) state_d = rpc_pkg::ST_LOOK;
            else if (sts_i.out_free) state_d = rpc_pkg::ST_IDLE;
          end
          default: begin
            if (sts_i.out_free) state_d = rpc_pkg::ST_IDLE;
          end
        endcase
      end
      rpc_pkg::ST_STORE: begin
        if ((sts_i.lock_free || sts_i.at_end) && sts_i.out_free) state_d = rpc_pkg::ST_IDLE;
      end
      rpc_pkg::ST_LOOK: begin
        if ((sts_i.match || sts_i.at_end) && sts_i.out_free) state_d = rpc_pkg::ST_IDLE;
      end
      default: state_d = rpc_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = (state_q == rpc_pkg::ST_IDLE);
    cmd_o.load = (state_q == rpc_pkg::ST_IDLE) && in_valid_i;
    cmd_o.act  = rpc_pkg::ACT_NONE;
    unique case (state_q)
      rpc_pkg::ST_DISPATCH: begin
        if (sts_i.out_free) begin
          unique case (sts_i.op)
            rpc_pkg::OP_STORE: begin
              if (!sts_i.enable) cmd_o.act = rpc_pkg::ACT_BLANK;
            end
            rpc_pkg::OP_LOOKUP: begin
              if (!sts_i.enable) cmd_o.act = rpc_pkg::ACT_MISS;
              else if (sts_i.is_marker) cmd_o.act = rpc_pkg::ACT_SKIP;
            end
            rpc_pkg::OP_SERVICE: begin
              cmd_o.act = sts_i.q_empty ? rpc_pkg::ACT_BLANK : rpc_pkg::ACT_POP;
            end
            default: cmd_o.act = rpc_pkg::ACT_BLANK;
          endcase
        end
      end
      rpc_pkg::ST_STORE: begin
        // Walk from the round-robin slot to the first unlocked one.
        if (!sts_i.lock_free && !sts_i.at_end) cmd_o.act = rpc_pkg::ACT_STEP;
        else if (sts_i.out_free) begin
          cmd_o.act = sts_i.lock_free ? rpc_pkg::ACT_STORE : rpc_pkg::ACT_BLANK;
        end
      end
      rpc_pkg::ST_LOOK: begin
        // Walk upward from slot zero; the first match ends the search.
        if (!sts_i.match && !sts_i.at_end) cmd_o.act = rpc_pkg::ACT_STEP;
        else if (sts_i.out_free) begin
          cmd_o.act = (sts_i.match && !sts_i.q_full) ? rpc_pkg::ACT_HIT : rpc_pkg::ACT_MISS;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/rpc_dp.sv
// Datapath of the relay packet cache: slot store, locks, service queue,
// counters and the result register. Depends on rpc_pkg and the assert header.
`include "relay_packet_cache_with_locks_top_assert.svh"

module rpc_dp #(
  parameter int unsigned MAX_SLOTS   = rpc_pkg::MAX_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = rpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpc_pkg::cfg_t    cfg_i,
  input  rpc_pkg::cmd_t    cmd_i,
  input  rpc_pkg::item_t   item_i,
  output rpc_pkg::sts_t    sts_o,
  output logic             res_valid_o,
  output rpc_pkg::result_t res_o,
  input  logic             res_ready_i
);

  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned NW = $clog2(MAX_SLOTS + 1) > rpc_pkg::NB_W ?
                               $clog2(MAX_SLOTS + 1) : rpc_pkg::NB_W;
  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Slot contents; the valid marks guard entries never stored.
  logic [rpc_pkg::SEQ_W-1:0] seq_mem [MAX_SLOTS];
  logic [rpc_pkg::SEQ_W-1:0] seq_rd_q;
  logic [SW-1:0]             q_mem [QUEUE_DEPTH];
  logic [SW-1:0]             q_rd_q;

  logic [MAX_SLOTS-1:0]      valid_q, valid_d;
  logic [MAX_SLOTS-1:0]      lock_q, lock_d;
  logic [SW-1:0]             next_slot_q, next_slot_d;
  logic [SW-1:0]             idx_q, idx_d;
  logic [SW-1:0]             start_q, start_d;
  logic [QW-1:0]             q_head_q, q_head_d;
  logic [QW-1:0]             q_tail_q, q_tail_d;
  logic [CW-1:0]             q_count_q, q_count_d;
  logic                      all_srv_q, all_srv_d;
  logic [rpc_pkg::HIT_W-1:0] hit_q, hit_d;
  rpc_pkg::item_t            item_q;
  logic                      out_valid_q, out_valid_d;
  rpc_pkg::result_t          res_q, res_d;

  logic [NW-1:0]             n_use;
  logic [NW-1:0]             n_last;
  logic [SW-1:0]             idx_inc;
  logic [SW-1:0]             cur_slot;
  logic [31:0]               idx_ext;
  logic [31:0]               q_rd_ext;
  logic                      emit;
  logic                      out_free;
  logic                      miss;
  logic                      serviced_now;

  // Slots in use: zero acts as one, large values clamp to MAX_SLOTS.
  always_comb begin
    if (cfg_i.num_blocks == '0) n_use = NW'(1);
    else if (32'(cfg_i.num_blocks) > 32'(MAX_SLOTS)) n_use = NW'(MAX_SLOTS);
    else n_use = NW'(cfg_i.num_blocks);
  end
  assign n_last = n_use - NW'(1);

  // Round-robin successor and the store start slot.
  assign idx_inc  = (NW'(idx_q) == n_last) ? '0 : idx_q + SW'(1);
  assign cur_slot = (NW'(next_slot_q) < n_use) ? next_slot_q : '0;
  assign idx_ext  = 32'(idx_q);
  assign q_rd_ext = 32'(q_rd_q);

  assign out_free = !out_valid_q || res_ready_i;
  assign emit     = (cmd_i.act != rpc_pkg::ACT_NONE) && (cmd_i.act != rpc_pkg::ACT_STEP);

  // Status to the controller.
  always_comb begin
    sts_o.op        = item_q.op;
    sts_o.enable    = cfg_i.cache_enable;
    sts_o.is_marker = (item_q.seq_no == cfg_i.invalid_marker);
    sts_o.lock_free = !lock_q[idx_q];
    sts_o.match     = valid_q[idx_q] && (seq_rd_q == item_q.seq_no);
    sts_o.at_end    = (idx_inc == start_q);
    sts_o.q_empty   = (q_count_q == '0);
    sts_o.q_full    = (q_count_q == CW'(QUEUE_DEPTH));
    sts_o.out_free  = out_free;
  end

  // Walk index: loaded on accept, advanced on a step.
  always_comb begin
    idx_d   = idx_q;
    start_d = start_q;
    if (cmd_i.load) begin
      idx_d   = (item_i.op == rpc_pkg::OP_STORE) ? cur_slot : '0;
      start_d = idx_d;
    end else if (cmd_i.act == rpc_pkg::ACT_STEP) begin
      idx_d = idx_inc;
    end
  end

  // A bulk interest stays serviced while every element hits or is empty.
  assign miss         = (cmd_i.act == rpc_pkg::ACT_MISS);
  assign serviced_now = all_srv_q && !miss;

  // State updates and the result word of a finishing action.
  always_comb begin
    valid_d     = valid_q;
    lock_d      = lock_q;
    next_slot_d = next_slot_q;
    q_head_d    = q_head_q;
    q_tail_d    = q_tail_q;
    q_count_d   = q_count_q;
    all_srv_d   = all_srv_q;
    hit_d       = hit_q;
    res_d       = '0;
    unique case (cmd_i.act)
      rpc_pkg::ACT_STORE: begin
        valid_d[idx_q]   = 1'b1;
        next_slot_d      = idx_inc;
        res_d.slot       = idx_ext[rpc_pkg::SLOT_W-1:0];
        res_d.slot_valid = 1'b1;
      end
      rpc_pkg::ACT_HIT: begin
        lock_d[idx_q]    = 1'b1;
        q_tail_d         = (q_tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_q + QW'(1);
        q_count_d        = q_count_q + CW'(1);
        hit_d            = hit_q + rpc_pkg::HIT_W'(1);
        res_d.slot       = idx_ext[rpc_pkg::SLOT_W-1:0];
        res_d.slot_valid = 1'b1;
        res_d.seq_out    = cfg_i.invalid_marker;
      end
      rpc_pkg::ACT_MISS, rpc_pkg::ACT_SKIP: begin
        res_d.seq_out = item_q.seq_no;
      end
      rpc_pkg::ACT_POP: begin
        lock_d[q_rd_q]     = 1'b0;
        q_head_d           = (q_head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + QW'(1);
        q_count_d          = q_count_q - CW'(1);
        res_d.slot         = q_rd_ext[rpc_pkg::SLOT_W-1:0];
        res_d.slot_valid   = 1'b1;
        res_d.more_pending = (q_count_q != CW'(1));
      end
      default: ;
    endcase
    // Lookup elements settle the forward decision on the last one.
    if (cmd_i.act == rpc_pkg::ACT_HIT || cmd_i.act == rpc_pkg::ACT_MISS ||
        cmd_i.act == rpc_pkg::ACT_SKIP) begin
      res_d.forward = item_q.last && !serviced_now;
      all_srv_d     = item_q.last ? 1'b1 : serviced_now;
    end
    res_d.hit_total = hit_d;
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) out_valid_d = 1'b1;
    else if (res_ready_i) out_valid_d = 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      lock_q      <= '0;
      next_slot_q <= '0;
      idx_q       <= '0;
      start_q     <= '0;
      q_head_q    <= '0;
      q_tail_q    <= '0;
      q_count_q   <= '0;
      all_srv_q   <= 1'b1;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      lock_q      <= lock_d;
      next_slot_q <= next_slot_d;
      idx_q       <= idx_d;
      start_q     <= start_d;
      q_head_q    <= q_head_d;
      q_tail_q    <= q_tail_d;
      q_count_q   <= q_count_d;
      all_srv_q   <= all_srv_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the accepted item and the result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (emit) res_q <= res_d;
  end

  // Slot sequence memory: one write port, one registered read at the walk index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == rpc_pkg::ACT_STORE) seq_mem[idx_q] <= item_q.seq_no;
    seq_rd_q <= seq_mem[idx_d];
  end

  // Service queue memory: pushed at the tail, read registered at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == rpc_pkg::ACT_HIT) q_mem[q_tail_q] <= idx_q;
    q_rd_q <= q_mem[q_head_q];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Checks on queue bookkeeping and action sequencing.
  `RPC_ASSERT_IMPL(a_lock_le_count, clk_i, rst_ni, 1'b1,
                   $countones(lock_q) <= int'(q_count_q), "more locked slots than queued entries")
  `RPC_ASSERT_IMPL(a_ptr_meet, clk_i, rst_ni,
                   (q_count_q == '0) || (q_count_q == CW'(QUEUE_DEPTH)),
                   q_head_q == q_tail_q, "queue pointers disagree with the count")
  `RPC_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, cmd_i.act == rpc_pkg::ACT_POP,
                   q_count_q != '0, "pop issued on an empty queue")
  `RPC_ASSERT_IMPL(a_store_unlocked, clk_i, rst_ni, cmd_i.act == rpc_pkg::ACT_STORE,
                   !lock_q[idx_q], "store into a locked slot")
  `RPC_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, emit, out_valid_q,
                   "finished word not presented on the result port")

endmodule

// File: hdl/relay_packet_cache_with_locks_top.sv
// Top level of the relay packet cache with slot locks.
// Depends on rpc_pkg, rpc_stream_if, rpc_cfg, rpc_ctrl and rpc_dp.
//
//   Channel   Direction  Word                      Handshake
//   item_i    in         rpc_pkg::item_t           valid/ready
//   result_o  out        rpc_pkg::result_t         valid/ready
//   APB       in/out     32-bit register access    psel/penable, pready high
//
// One item at a time: a service tick, a disabled store or lookup, an empty
// element or a reserved op finishes straight from dispatch; a store or lookup
// then walks the slot memory one slot per cycle, over at most the slots in use
// (num_blocks, zero taken as one). Ready returns as the registered result
// appears; a held result stalls only a later item's finishing step. Reset is
// asynchronous and clears all control state.
module relay_packet_cache_with_locks_top #(
  parameter int unsigned MAX_SLOTS   = rpc_pkg::MAX_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = rpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rpc_stream_if.sink                  item_i,
  rpc_stream_if.source                result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpc_pkg::PADDR_W-1:0] paddr,
  input  logic [rpc_pkg::PDATA_W-1:0] pwdata,
  output logic [rpc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  rpc_pkg::cfg_t    cfg;
  rpc_pkg::cmd_t    cmd;
  rpc_pkg::sts_t    sts;
  rpc_pkg::item_t   item_word;
  rpc_pkg::result_t res_word;
  logic             in_ready;
  logic             res_valid;

  assign item_word      = item_i.data;
  assign item_i.ready   = in_ready;
  assign result_o.valid = res_valid;
  assign result_o.data  = res_word;

  // Configuration registers.
  rpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer.
  rpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot store, queue and result register.
  rpc_dp #(
    .MAX_SLOTS   (MAX_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .item_i      (item_word),
    .sts_o       (sts),
    .res_valid_o (res_valid),
    .res_o       (res_word),
    .res_ready_i (result_o.ready)
  );

endmodule

// File: verif/tb_relay_packet_cache_with_locks_top.sv
// Self-checking testbench for the relay packet cache with slot locks.
// Drives item words, checks result words against an in-bench cache predictor.
// Depends on rpc_pkg, rpc_stream_if and relay_packet_cache_with_locks_top.
module tb_relay_packet_cache_with_locks_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT  = rpc_pkg::MAX_SLOTS_DEF;
  localparam int unsigned QUEUE_SLOTS = rpc_pkg::QUEUE_DEPTH_DEF;
  localparam logic [rpc_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 45;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rpc_pkg::PADDR_W-1:0] paddr;
  logic [rpc_pkg::PDATA_W-1:0] pwdata;
  logic [rpc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  rpc_stream_if #(.T(rpc_pkg::item_t))   item_if ();
  rpc_stream_if #(.T(rpc_pkg::result_t)) result_if ();

  relay_packet_cache_with_locks_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the cache state and registers.
  logic [rpc_pkg::SEQ_W-1:0]  cached_seq [SLOT_COUNT];
  logic                       cached_live [SLOT_COUNT];
  logic                       slot_locked [SLOT_COUNT];
  int unsigned                rr_slot = 0;
  logic [rpc_pkg::SLOT_W-1:0] service_fifo [$];
  logic                       bulk_serviced = 1'b1;
  logic [rpc_pkg::HIT_W-1:0]  hit_count = '0;
  logic                       cfg_enable = 1'b0;
  logic [rpc_pkg::NB_W-1:0]   cfg_blocks = rpc_pkg::NUM_BLOCKS_RST;
  logic [rpc_pkg::SEQ_W-1:0]  cfg_marker = rpc_pkg::INVALID_MARKER_RST;

  // Words waiting to be sent and replies still owed by the block.
  rpc_pkg::item_t   pending_items [$];
  rpc_pkg::result_t due_replies [$];
  int unsigned      items_queued = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      reply_index = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  logic             rx_hold = 1'b0;
  int unsigned      quiet_cycles = 0;
  rpc_pkg::result_t reply_want;
  rpc_pkg::result_t reply_got;

  // Computes the reply to one accepted word and advances the predictor state.
  function automatic rpc_pkg::result_t predict_cache_reply(rpc_pkg::item_t it);
    rpc_pkg::result_t r;
    int unsigned n, start, cur, k;
    bit found;
    r = '0;
    cur = 0;
    n = (cfg_blocks == 0) ? 1 : ((cfg_blocks > SLOT_COUNT) ? SLOT_COUNT : cfg_blocks);
    case (it.op)
      rpc_pkg::OP_STORE: begin
        if (cfg_enable) begin
          // Round robin from the current slot, skipping locked slots.
          start = (rr_slot < n) ? rr_slot : 0;
          cur = start;
          found = !slot_locked[start];
          for (k = 1; k < n && !found; k++) begin
            if (!slot_locked[(start + k) % n]) begin
              cur = (start + k) % n;
              found = 1'b1;
            end
          end
          if (found) begin
            cached_seq[cur] = it.seq_no;
            cached_live[cur] = 1'b1;
            rr_slot = (cur + 1) % n;
            r.slot = cur[rpc_pkg::SLOT_W-1:0];
            r.slot_valid = 1'b1;
          end
        end
      end
      rpc_pkg::OP_LOOKUP: begin
        r.seq_out = it.seq_no;
        if (!cfg_enable) begin
          bulk_serviced = 1'b0;
        end else if (it.seq_no != cfg_marker) begin
          // Lowest live slot holding the sequence number; locks do not hide it.
          found = 1'b0;
          for (k = 0; k < n && !found; k++) begin
            if (cached_live[k] && cached_seq[k] == it.seq_no) begin
              cur = k;
              found = 1'b1;
            end
          end
          if (found && service_fifo.size() < QUEUE_SLOTS) begin
            slot_locked[cur] = 1'b1;
            service_fifo.push_back(cur[rpc_pkg::SLOT_W-1:0]);
            hit_count = hit_count + 1'b1;
            r.seq_out = cfg_marker;
            r.slot = cur[rpc_pkg::SLOT_W-1:0];
            r.slot_valid = 1'b1;
          end else begin
            bulk_serviced = 1'b0;
          end
        end
        if (it.last) begin
          r.forward = !bulk_serviced;
          bulk_serviced = 1'b1;
        end
      end
      rpc_pkg::OP_SERVICE: begin
        if (service_fifo.size() != 0) begin
          r.slot = service_fifo.pop_front();
          slot_locked[r.slot] = 1'b0;
          r.slot_valid = 1'b1;
          r.more_pending = (service_fifo.size() != 0);
        end
      end
      default: begin
      end
    endcase
    r.hit_total = hit_count;
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic log_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("reply %0d field %s: got %h, expected %h",
                             reply_index, name, got, want));
    end
  endtask

  // Word driver: holds a word until it is taken, then predicts its reply.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      item_if.data <= '0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        due_replies.push_back(predict_cache_reply(item_if.data));
      end
      if (!item_if.valid || item_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_if.valid <= 1'b1;
          item_if.data <= pending_items.pop_front();
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: random back-pressure and field-by-field compare.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (due_replies.size() == 0) begin
          log_mismatch($sformatf("reply %0d arrived with nothing expected", reply_index));
        end else begin
          reply_want = due_replies.pop_front();
          reply_got = result_if.data;
          check_field("slot", 16'(reply_got.slot), 16'(reply_want.slot));
          check_field("slot_valid", 16'(reply_got.slot_valid), 16'(reply_want.slot_valid));
          check_field("seq_out", reply_got.seq_out, reply_want.seq_out);
          check_field("forward", 16'(reply_got.forward), 16'(reply_want.forward));
          check_field("more_pending", 16'(reply_got.more_pending),
                      16'(reply_want.more_pending));
          check_field("hit_total", reply_got.hit_total, reply_want.hit_total);
        end
        reply_index++;
      end
      result_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("relay_packet_cache_with_locks_top: mismatch");
      $finish;
    end
  end

  // One APB transfer; read data is sampled mid-way through the access cycle.
  task automatic apb_transfer(input logic [1:0] idx, input logic wr,
                              input logic [rpc_pkg::PDATA_W-1:0] wdata,
                              output logic [rpc_pkg::PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes all three registers, mirrors them, and reads each one back.
  task automatic set_config(input logic en, input logic [rpc_pkg::NB_W-1:0] nb,
                            input logic [rpc_pkg::SEQ_W-1:0] marker);
    logic [rpc_pkg::PDATA_W-1:0] rd;
    apb_transfer(rpc_pkg::REG_CACHE_ENABLE, 1'b1, rpc_pkg::PDATA_W'(en), rd);
    apb_transfer(rpc_pkg::REG_NUM_BLOCKS, 1'b1, rpc_pkg::PDATA_W'(nb), rd);
    apb_transfer(rpc_pkg::REG_INVALID_MARKER, 1'b1, rpc_pkg::PDATA_W'(marker), rd);
    cfg_enable = en;
    cfg_blocks = nb;
    cfg_marker = marker;
    apb_transfer(rpc_pkg::REG_CACHE_ENABLE, 1'b0, '0, rd);
    if (rd[0] !== en) log_mismatch($sformatf("cache_enable reads %h", rd));
    apb_transfer(rpc_pkg::REG_NUM_BLOCKS, 1'b0, '0, rd);
    if (rd[rpc_pkg::NB_W-1:0] !== nb) log_mismatch($sformatf("num_blocks reads %h", rd));
    apb_transfer(rpc_pkg::REG_INVALID_MARKER, 1'b0, '0, rd);
    if (rd[rpc_pkg::SEQ_W-1:0] !== marker) begin
      log_mismatch($sformatf("invalid_marker reads %h", rd));
    end
  endtask

  task automatic queue_item(input logic [rpc_pkg::OP_W-1:0] op,
                            input logic [rpc_pkg::SEQ_W-1:0] seq, input logic last);
    rpc_pkg::item_t it;
    it.op = op;
    it.seq_no = seq;
    it.last = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Mostly store / bulk interest / service rounds over a small pool of
  // sequence numbers, with some noise words and some interests left open.
  task automatic fill_phase(input int unsigned n_items, input int unsigned svc_max);
    logic [rpc_pkg::SEQ_W-1:0] pool [6];
    logic [rpc_pkg::SEQ_W-1:0] s;
    int unsigned target, cnt, k;
    bit close_bulk;
    foreach (pool[p]) pool[p] = rpc_pkg::SEQ_W'($urandom);
    target = items_queued + n_items;
    while (items_queued < target) begin
      if ($urandom_range(99) < 15) begin
        queue_item(rpc_pkg::OP_W'($urandom_range(3)), rpc_pkg::SEQ_W'($urandom),
                   1'($urandom_range(1)));
      end else begin
        cnt = $urandom_range(1, 4);
        for (k = 0; k < cnt; k++) begin
          queue_item(rpc_pkg::OP_STORE, pool[$urandom_range(5)], 1'($urandom_range(1)));
        end
        cnt = $urandom_range(1, 5);
        close_bulk = ($urandom_range(9) != 0);
        for (k = 0; k < cnt; k++) begin
          case ($urandom_range(9))
            0: s = cfg_marker;
            1: s = rpc_pkg::SEQ_W'($urandom);
            default: s = pool[$urandom_range(5)];
          endcase
          queue_item(rpc_pkg::OP_LOOKUP, s, close_bulk && (k == cnt - 1));
        end
        cnt = $urandom_range(0, svc_max);
        for (k = 0; k < cnt; k++) begin
          queue_item(rpc_pkg::OP_SERVICE, rpc_pkg::SEQ_W'($urandom), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  // Keeps the receiver from taking words so the block backs up.
  task automatic hold_receiver(input int unsigned cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(negedge clk_i);
    rx_hold = 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    @(negedge clk_i);
    case (mode)
      0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin send_idle_pct = 63; rx_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rx_stall_pct = 63; end
      default: begin send_idle_pct = 22; rx_stall_pct = 22; end
    endcase
  endtask

  // Waits until every word was sent and every reply came back, then a tail.
  task automatic wait_idle(input int unsigned tail);
    while (pending_items.size() != 0 || item_if.valid || due_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (tail) @(negedge clk_i);
  endtask

  // Sequence: reset, directed words, then random phases over several settings.
  initial begin
    int unsigned ph;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    foreach (cached_seq[i]) begin
      cached_seq[i] = '0;
      cached_live[i] = 1'b0;
      slot_locked[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Caching disabled after reset: stores do nothing, interests forward.
    set_idling(0);
    queue_item(rpc_pkg::OP_STORE, 16'd5, 1'b0);
    queue_item(rpc_pkg::OP_LOOKUP, 16'd5, 1'b1);
    queue_item(rpc_pkg::OP_LOOKUP, 16'hFFFF, 1'b0);
    queue_item(rpc_pkg::OP_SERVICE, 16'd0, 1'b0);
    queue_item(OP_RESERVED, 16'hFFFF, 1'b1);
    wait_idle(DRAIN_CYCLES);

    // Two slots, marker zero: hits, all slots locked, pops, empty queue.
    set_config(1'b1, 5'd2, 16'h0000);
    set_idling(0);
    queue_item(rpc_pkg::OP_STORE, 16'hFFFF, 1'b1);
    queue_item(rpc_pkg::OP_STORE, 16'h1234, 1'b0);
    queue_item(rpc_pkg::OP_LOOKUP, 16'hFFFF, 1'b0);
    queue_item(rpc_pkg::OP_LOOKUP, 16'h1234, 1'b0);
    queue_item(rpc_pkg::OP_LOOKUP, 16'h0000, 1'b1);
    queue_item(rpc_pkg::OP_STORE, 16'd7, 1'b0);
    queue_item(rpc_pkg::OP_SERVICE, 16'd0, 1'b0);
    queue_item(rpc_pkg::OP_STORE, 16'd7, 1'b0);
    queue_item(rpc_pkg::OP_LOOKUP, 16'd9, 1'b1);
    queue_item(rpc_pkg::OP_LOOKUP, 16'h0000, 1'b0);
    queue_item(rpc_pkg::OP_LOOKUP, 16'd7, 1'b1);
    queue_item(rpc_pkg::OP_SERVICE, 16'hFFFF, 1'b1);
    queue_item(rpc_pkg::OP_SERVICE, 16'd0, 1'b0);
    queue_item(rpc_pkg::OP_SERVICE, 16'd0, 1'b0);
    queue_item(OP_RESERVED, 16'h0000, 1'b0);
    wait_idle(DRAIN_CYCLES);

    // Random phases; each idling mode is used twice.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(1'b1, 5'd16, 16'hFFFF);
        1: set_config(1'b1, 5'd1, 16'h0000);
        2: set_config(1'b1, 5'd0, rpc_pkg::SEQ_W'($urandom));
        3: set_config(1'b1, 5'd31, rpc_pkg::SEQ_W'($urandom));
        4: set_config(1'b0, 5'd8, rpc_pkg::SEQ_W'($urandom));
        5: set_config(1'b1, 5'd4, 16'hFFFF);
        6: set_config(1'b1, 5'd17, rpc_pkg::SEQ_W'($urandom));
        default: set_config(1'b1, 5'd2, 16'h0000);
      endcase
      set_idling(ph % 4);
      fill_phase(PHASE_ITEMS, (ph == 3) ? 0 : (ph % 4) + 1);
      if (ph == 5) begin
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
      end
      wait_idle(DRAIN_CYCLES);
    end

    if (mismatch_count == 0) begin
      $display("relay_packet_cache_with_locks_top: match");
    end else begin
      $display("relay_packet_cache_with_locks_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/rpc_pkg.sv
hdl/rpc_stream_if.sv
hdl/rpc_cfg.sv
hdl/rpc_ctrl.sv
hdl/rpc_dp.sv
hdl/relay_packet_cache_with_locks_top.sv
verif/tb_relay_packet_cache_with_locks_top.sv
